// ----- rtl/core/tcls_pkg.sv -----
// Shared types, event codes and sequencer states of the touch tap classifier.
package tcls_pkg;

  // Event types and codes
  localparam logic [15:0] EVT_SYN     = 16'h0000;
  localparam logic [15:0] EVT_KEY     = 16'h0001;
  localparam logic [15:0] EVT_ABS     = 16'h0003;
  localparam logic [15:0] CODE_MT_X   = 16'h0035;
  localparam logic [15:0] CODE_MT_Y   = 16'h0036;
  localparam logic [15:0] CODE_TOUCH  = 16'h014A;
  localparam logic [15:0] CODE_REPORT = 16'h0000;

  // Result kinds
  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LIMIT    = 3'd6;
  localparam int CFG_DATA_W = 32;

  // Screen size limits and divider shape
  localparam int SIZE_W = 13;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;
  localparam int POS_W = 12;
  localparam int DIV_STEPS = POS_W;
  localparam int CNT_W = 4;
  localparam int PROD_W = 44;

  typedef struct packed {
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
  } ev_t;

  typedef struct packed {
    logic [1:0]       touch_kind;
    logic [POS_W-1:0] screen_x;
    logic [POS_W-1:0] screen_y;
    logic             is_tap;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAP_D,
    ST_TAP_LO,
    ST_TAP_HI,
    ST_DIFF,
    ST_SPAN,
    ST_SAT,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/touch_event_tap_classifier.sv -----
// Touch event tap classifier: event decode, shared subtractor, sequencer and scaling divider.
//
// Input events (type, code, value) arrive on in_valid / in_stall / in_data, one beat each.
// Results (kind, screen X, screen Y, tap flag) leave on out_valid / out_stall / out_data.
// Position events and ignored events are taken while idle and give no result.
// A touch press, a release or a sync report while held runs the sequencer: one shared
// 34-bit subtractor forms differences and spans, then does a 12-step restoring division
// per axis after one multiplication by the screen size. A release with the finger held
// first runs the tap compares on both axes. The next event beat is taken only once the
// sequencer is back in idle.
// in_stall is high while the sequencer runs; the next event is taken once the result
// sits in the output register, even while that register is still stalled.
// A stalled result holds out_data; a finished result waits in the sequencer until
// the output register frees up.
// Configuration is written through cfg_wen / cfg_index / cfg_data; the user must write it
// only while idle, since the block does not enforce this. Screen sizes are fitted to
// 1..4096 when written, indexes beyond the list are dropped. Reset (rst, synchronous)
// restores the register defaults, clears positions, the held flag and the output valid.
module touch_event_tap_classifier (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tcls_pkg::ev_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tcls_pkg::res_t                      out_data,
  input  logic                                cfg_wen,
  input  logic [tcls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcls_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration
  logic signed [31:0]              raw_x_low, raw_x_high, raw_y_low, raw_y_high;
  logic [tcls_pkg::SIZE_W-1:0]     screen_width, screen_height;
  logic [30:0]                     move_limit;

  // Tracking state
  logic signed [31:0] pos_x_latest, pos_y_latest, press_x, press_y;
  logic               finger_held;

  // Sequencer and datapath
  tcls_pkg::state_t               state, state_next;
  logic                           axis;
  logic [1:0]                     kind;
  logic                           tap;
  logic signed [32:0]             dlt;
  logic signed [32:0]             diff;
  logic [31:0]                    span;
  logic                           neg, sat;
  logic [tcls_pkg::PROD_W-1:0]    prod;
  logic [31:0]                    rem;
  logic [tcls_pkg::POS_W-1:0]     low;
  logic [tcls_pkg::CNT_W-1:0]     cnt;
  logic [tcls_pkg::POS_W-1:0]     res_x, res_y;

  // Shared subtractor and multiplier
  logic signed [33:0] sub_a, sub_b, sub_y;
  logic signed [46:0] mul_y;

  // Axis selection
  logic signed [31:0]          lat_ax, press_ax, lo_ax, hi_ax;
  logic [tcls_pkg::SIZE_W-1:0] size_ax;
  logic [tcls_pkg::SIZE_W-1:0] size_m1;
  logic [tcls_pkg::POS_W-1:0]  pos_res;
  logic [tcls_pkg::SIZE_W-1:0] size_fit;

  // Event decode
  logic in_fire, is_abs, is_touch, val_one, val_zero, is_sync, out_free;

  assign lat_ax   = axis ? pos_y_latest : pos_x_latest;
  assign press_ax = axis ? press_y : press_x;
  assign lo_ax    = axis ? raw_y_low : raw_x_low;
  assign hi_ax    = axis ? raw_y_high : raw_x_high;
  assign size_ax  = axis ? screen_height : screen_width;
  assign size_m1  = size_ax - tcls_pkg::SIZE_W'(1);

  assign sub_y = sub_a - sub_b;
  assign mul_y = 47'(diff) * $signed({1'b0, size_ax});

  assign in_fire  = in_valid && !in_stall;
  assign is_abs   = in_data.ev_type == tcls_pkg::EVT_ABS;
  assign is_touch = (in_data.ev_type == tcls_pkg::EVT_KEY) &&
                    (in_data.ev_code == tcls_pkg::CODE_TOUCH);
  assign val_one  = in_data.ev_value == 32'sd1;
  assign val_zero = in_data.ev_value == 32'sd0;
  assign is_sync  = (in_data.ev_type == tcls_pkg::EVT_SYN) &&
                    (in_data.ev_code == tcls_pkg::CODE_REPORT) && finger_held;
  assign out_free = !out_valid || !out_stall;

  // Clamp the scaled position: below zero to zero, past the edge to size minus one
  assign pos_res = neg ? '0 : (sat ? size_m1[tcls_pkg::POS_W-1:0] : low);

  // Fit a written screen size into 1..4096
  always_comb begin
    size_fit = cfg_data[tcls_pkg::SIZE_W-1:0];
    if (size_fit == '0) begin
      size_fit = tcls_pkg::SIZE_W'(1);
    end else if (size_fit > tcls_pkg::SIZE_MAX) begin
      size_fit = tcls_pkg::SIZE_MAX;
    end
  end

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcls_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick next state and subtractor operands
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    sub_a      = '0;
    sub_b      = '0;
    unique case (state)
      tcls_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (is_touch && val_one) begin
            state_next = tcls_pkg::ST_DIFF;
          end else if (is_touch && val_zero) begin
            state_next = finger_held ? tcls_pkg::ST_TAP_D : tcls_pkg::ST_DIFF;
          end else if (!is_abs && is_sync) begin
            state_next = tcls_pkg::ST_DIFF;
          end
        end
      end
      tcls_pkg::ST_TAP_D: begin
        sub_a      = 34'(lat_ax);
        sub_b      = 34'(press_ax);
        state_next = tcls_pkg::ST_TAP_LO;
      end
      tcls_pkg::ST_TAP_LO: begin
        sub_a      = 34'(dlt);
        sub_b      = $signed({3'b000, move_limit});
        state_next = tcls_pkg::ST_TAP_HI;
      end
      tcls_pkg::ST_TAP_HI: begin
        sub_a      = 34'(dlt);
        sub_b      = -$signed({3'b000, move_limit});
        state_next = axis ? tcls_pkg::ST_DIFF : tcls_pkg::ST_TAP_D;
      end
      tcls_pkg::ST_DIFF: begin
        sub_a      = 34'(lat_ax);
        sub_b      = 34'(lo_ax);
        state_next = tcls_pkg::ST_SPAN;
      end
      tcls_pkg::ST_SPAN: begin
        sub_a      = 34'(hi_ax);
        sub_b      = 34'(lo_ax);
        state_next = tcls_pkg::ST_SAT;
      end
      tcls_pkg::ST_SAT: begin
        sub_a      = 34'(diff);
        sub_b      = $signed({2'b00, span});
        state_next = tcls_pkg::ST_LOAD;
      end
      tcls_pkg::ST_LOAD: begin
        state_next = tcls_pkg::ST_DIV;
      end
      tcls_pkg::ST_DIV: begin
        sub_a = $signed({1'b0, rem, low[tcls_pkg::POS_W-1]});
        sub_b = $signed({2'b00, span});
        if (cnt == tcls_pkg::CNT_W'(tcls_pkg::DIV_STEPS - 1)) begin
          state_next = tcls_pkg::ST_STORE;
        end
      end
      tcls_pkg::ST_STORE: begin
        state_next = axis ? tcls_pkg::ST_DONE : tcls_pkg::ST_DIFF;
      end
      tcls_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tcls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcls_pkg::ST_IDLE;
      end
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_x_low     <= 32'sd0;
      raw_x_high    <= 32'sd4095;
      raw_y_low     <= 32'sd0;
      raw_y_high    <= 32'sd4095;
      screen_width  <= tcls_pkg::SIZE_W'(1080);
      screen_height <= tcls_pkg::SIZE_W'(2400);
      move_limit    <= 31'd20;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        tcls_pkg::CFG_RAW_X_LOW:     raw_x_low     <= $signed(cfg_data);
        tcls_pkg::CFG_RAW_X_HIGH:    raw_x_high    <= $signed(cfg_data);
        tcls_pkg::CFG_RAW_Y_LOW:     raw_y_low     <= $signed(cfg_data);
        tcls_pkg::CFG_RAW_Y_HIGH:    raw_y_high    <= $signed(cfg_data);
        tcls_pkg::CFG_SCREEN_WIDTH:  screen_width  <= size_fit;
        tcls_pkg::CFG_SCREEN_HEIGHT: screen_height <= size_fit;
        tcls_pkg::CFG_MOVE_LIMIT:    move_limit    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Track positions, press point and held flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x_latest <= 32'sd0;
      pos_y_latest <= 32'sd0;
      press_x      <= 32'sd0;
      press_y      <= 32'sd0;
      finger_held  <= 1'b0;
    end else if (in_fire) begin
      if (is_abs) begin
        if (in_data.ev_code == tcls_pkg::CODE_MT_X) begin
          pos_x_latest <= in_data.ev_value;
        end else if (in_data.ev_code == tcls_pkg::CODE_MT_Y) begin
          pos_y_latest <= in_data.ev_value;
        end
      end else if (is_touch && val_one) begin
        finger_held <= 1'b1;
        press_x     <= pos_x_latest;
        press_y     <= pos_y_latest;
      end else if (is_touch && val_zero) begin
        finger_held <= 1'b0;
      end
    end
  end

  // Advance the datapath under the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      tcls_pkg::ST_IDLE: begin
        axis <= 1'b0;
        if (is_touch && val_one) begin
          kind <= tcls_pkg::KIND_DOWN;
          tap  <= 1'b0;
        end else if (is_touch && val_zero) begin
          kind <= tcls_pkg::KIND_UP;
          tap  <= finger_held;
        end else begin
          kind <= tcls_pkg::KIND_MOVE;
          tap  <= 1'b0;
        end
      end
      tcls_pkg::ST_TAP_D: begin
        dlt <= sub_y[32:0];
      end
      tcls_pkg::ST_TAP_LO: begin
        // drop the tap when the move reaches the limit upward
        if (!sub_y[33]) begin
          tap <= 1'b0;
        end
      end
      tcls_pkg::ST_TAP_HI: begin
        // drop the tap when the move reaches the limit downward
        if (sub_y[33] || sub_y == '0) begin
          tap <= 1'b0;
        end
        axis <= !axis;
      end
      tcls_pkg::ST_DIFF: begin
        diff <= sub_y[32:0];
      end
      tcls_pkg::ST_SPAN: begin
        // treat a span below one as one
        if (sub_y[33] || sub_y == '0) begin
          span <= 32'd1;
        end else begin
          span <= sub_y[31:0];
        end
      end
      tcls_pkg::ST_SAT: begin
        neg  <= diff[32];
        sat  <= !sub_y[33];
        prod <= mul_y[tcls_pkg::PROD_W-1:0];
      end
      tcls_pkg::ST_LOAD: begin
        rem <= prod[tcls_pkg::PROD_W-1:tcls_pkg::POS_W];
        low <= prod[tcls_pkg::POS_W-1:0];
        cnt <= '0;
      end
      tcls_pkg::ST_DIV: begin
        // one restoring step: quotient bit shifts into the low word
        if (!sub_y[33]) begin
          rem <= sub_y[31:0];
        end else begin
          rem <= {rem[30:0], low[tcls_pkg::POS_W-1]};
        end
        low <= {low[tcls_pkg::POS_W-2:0], !sub_y[33]};
        cnt <= cnt + tcls_pkg::CNT_W'(1);
      end
      tcls_pkg::ST_STORE: begin
        if (axis) begin
          res_y <= pos_res;
        end else begin
          res_x <= pos_res;
        end
        axis <= 1'b1;
      end
      default: ;
    endcase
  end

  // Load the output register and drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tcls_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcls_pkg::ST_DONE && out_free) begin
      out_data.touch_kind <= kind;
      out_data.screen_x   <= res_x;
      out_data.screen_y   <= res_y;
      out_data.is_tap     <= tap;
    end
  end

endmodule

// ----- tb/touch_event_tap_classifier_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the touch event tap classifier: directed and random event streams.
module touch_event_tap_classifier_test;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int ITEM_TARGET = 900;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 100;
  localparam logic [tcls_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [15:0] EVT_REL = 16'h0002;
  localparam logic [15:0] CODE_MT_TRACK = 16'h0037;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tcls_pkg::ev_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tcls_pkg::res_t out_data;
  logic cfg_wen = 1'b0;
  logic [tcls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tcls_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow settings and touch state used by the predictor
  longint lo_x = 0, hi_x = 4095, lo_y = 0, hi_y = 4095;
  longint width_px = 1080, height_px = 2400, tap_limit = 20;
  longint last_x = 0, last_y = 0, down_x = 0, down_y = 0;
  bit touching = 1'b0;

  tcls_pkg::res_t expected_touches[$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  bit calm = 1'b0;
  logic hold_off_req = 1'b0;
  bit hold_taken = 1'b0;
  int stall_left = 0;

  touch_event_tap_classifier dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Scale a raw coordinate to the screen, truncating toward zero, then clamp
  function automatic logic [tcls_pkg::POS_W-1:0] to_screen(longint raw, longint lo, longint hi,
                                                           longint size);
    longint span;
    longint q;
    span = hi - lo;
    if (span < 1) span = 1;
    q = ((raw - lo) * size) / span;
    if (q < 0) q = 0;
    if (q > size - 1) q = size - 1;
    return tcls_pkg::POS_W'(q);
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Advance the touch state by one beat; return 1 when a result is due
  function automatic bit predict_touch(tcls_pkg::ev_t e, output tcls_pkg::res_t r);
    longint v;
    bit hit;
    v = longint'($signed(e.ev_value));
    hit = 1'b0;
    r = '0;
    if (e.ev_type == tcls_pkg::EVT_ABS) begin
      if (e.ev_code == tcls_pkg::CODE_MT_X) last_x = v;
      else if (e.ev_code == tcls_pkg::CODE_MT_Y) last_y = v;
    end else if (e.ev_type == tcls_pkg::EVT_KEY && e.ev_code == tcls_pkg::CODE_TOUCH) begin
      if (v == 1) begin
        touching = 1'b1;
        down_x = last_x;
        down_y = last_y;
        r.touch_kind = tcls_pkg::KIND_DOWN;
        hit = 1'b1;
      end else if (v == 0) begin
        r.is_tap = touching && magnitude(last_x - down_x) < tap_limit
                   && magnitude(last_y - down_y) < tap_limit;
        touching = 1'b0;
        r.touch_kind = tcls_pkg::KIND_UP;
        hit = 1'b1;
      end
    end else if (e.ev_type == tcls_pkg::EVT_SYN && e.ev_code == tcls_pkg::CODE_REPORT
                 && touching) begin
      r.touch_kind = tcls_pkg::KIND_MOVE;
      hit = 1'b1;
    end
    if (hit) begin
      r.screen_x = to_screen(last_x, lo_x, hi_x, width_px);
      r.screen_y = to_screen(last_y, lo_y, hi_y, height_px);
    end
    return hit;
  endfunction

  function automatic tcls_pkg::ev_t make_event(logic [15:0] kind, logic [15:0] code,
                                               logic [31:0] value);
    tcls_pkg::ev_t e;
    e.ev_type = kind;
    e.ev_code = code;
    e.ev_value = value;
    return e;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offer one beat, hold it until taken, then predict its result
  task automatic send_event(tcls_pkg::ev_t e);
    int gap;
    tcls_pkg::res_t r;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= e;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (predict_touch(e, r)) begin
      expected_touches = {expected_touches, r};
    end
  endtask

  // Drain all results, then let a result-free beat finish
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_touches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [tcls_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      tcls_pkg::CFG_RAW_X_LOW: lo_x = longint'($signed(value));
      tcls_pkg::CFG_RAW_X_HIGH: hi_x = longint'($signed(value));
      tcls_pkg::CFG_RAW_Y_LOW: lo_y = longint'($signed(value));
      tcls_pkg::CFG_RAW_Y_HIGH: hi_y = longint'($signed(value));
      tcls_pkg::CFG_SCREEN_WIDTH: begin
        width_px = longint'(value[tcls_pkg::SIZE_W-1:0]);
        if (width_px < 1) width_px = 1;
        if (width_px > 4096) width_px = 4096;
      end
      tcls_pkg::CFG_SCREEN_HEIGHT: begin
        height_px = longint'(value[tcls_pkg::SIZE_W-1:0]);
        if (height_px < 1) height_px = 1;
        if (height_px > 4096) height_px = 4096;
      end
      tcls_pkg::CFG_MOVE_LIMIT: tap_limit = longint'(value[30:0]);
      default: ;
    endcase
  endtask

  // Write every register, poke the unused index, then drop the enable
  task automatic program_regs(logic [31:0] xl, logic [31:0] xh, logic [31:0] yl,
                              logic [31:0] yh, logic [31:0] w, logic [31:0] h,
                              logic [31:0] lim);
    put_reg(tcls_pkg::CFG_RAW_X_LOW, xl);
    put_reg(tcls_pkg::CFG_RAW_X_HIGH, xh);
    put_reg(tcls_pkg::CFG_RAW_Y_LOW, yl);
    put_reg(tcls_pkg::CFG_RAW_Y_HIGH, yh);
    put_reg(tcls_pkg::CFG_SCREEN_WIDTH, w);
    put_reg(tcls_pkg::CFG_SCREEN_HEIGHT, h);
    put_reg(tcls_pkg::CFG_MOVE_LIMIT, lim);
    put_reg(CFG_UNUSED, $urandom);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinate mostly inside the configured range, sometimes outside or anywhere
  function automatic logic [31:0] pick_coord(longint lo, longint hi);
    longint span;
    bit [63:0] r;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom;
    if (sel == 1) return 32'(lo - longint'($urandom_range(1, 2000)));
    if (sel == 2) return 32'(hi + longint'($urandom_range(1, 2000)));
    span = hi - lo;
    if (span < 0) span = 0;
    r = {$urandom, $urandom};
    return 32'(lo + longint'(r % (64'(span) + 64'd1)));
  endfunction

  function automatic longint jitter(longint scale);
    longint s;
    s = ($urandom_range(0, 3) == 0) ? 4 * scale : scale;
    return longint'($urandom_range(0, 32'(2 * s))) - s;
  endfunction

  function automatic tcls_pkg::ev_t noise_event();
    case ($urandom_range(0, 6))
      0: return tcls_pkg::ev_t'({$urandom, $urandom});
      1: return make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, $urandom);
      2: return make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH,
                           ($urandom_range(0, 1) == 0) ? 32'd2 : 32'hFFFF_FFFF);
      3: return make_event(tcls_pkg::EVT_SYN, 16'($urandom_range(1, 65535)), $urandom);
      4: return make_event(tcls_pkg::EVT_ABS, 16'($urandom), $urandom);
      5: return make_event(16'($urandom), tcls_pkg::CODE_TOUCH, 32'($urandom_range(0, 1)));
      default: return make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH,
                                 32'($urandom_range(0, 1)));
    endcase
  endfunction

  // Press, a few moves with reports, release; some gestures break off or carry noise
  task automatic run_gesture();
    int moves;
    longint scale;
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_X, pick_coord(lo_x, hi_x)));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_Y, pick_coord(lo_y, hi_y)));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    scale = (tap_limit > 0 && tap_limit < 20000) ? tap_limit : 20000;
    moves = $urandom_range(0, 4);
    repeat (moves) begin
      if ($urandom_range(0, 2) != 0)
        send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_X,
                              32'(last_x + jitter(scale))));
      if ($urandom_range(0, 2) != 0)
        send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_Y,
                              32'(last_y + jitter(scale))));
      send_event(make_event(tcls_pkg::EVT_SYN, tcls_pkg::CODE_REPORT, $urandom));
      if ($urandom_range(0, 9) == 0) send_event(noise_event());
    end
    if ($urandom_range(0, 9) != 0)
      send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
  endtask

  task automatic random_range(output logic [31:0] lo, output logic [31:0] hi);
    longint base;
    longint width;
    case ($urandom_range(0, 5))
      0: base = longint'($signed($urandom));
      1: base = -64'sd2147483648;
      default: base = longint'($urandom_range(0, 2000)) - 1000;
    endcase
    case ($urandom_range(0, 7))
      0: width = 0;
      1: width = -longint'($urandom_range(1, 5000));
      2: width = longint'($urandom);
      default: width = longint'($urandom_range(1, 70000));
    endcase
    lo = 32'(base);
    hi = 32'(base + width);
  endtask

  function automatic logic [31:0] random_size();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'h1FFF;
      2: return 32'd4096;
      3: return 32'd1;
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  // Reset settings: lone release, clamps, repeated press, ignored events, taps
  task automatic test_defaults();
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
    send_event(make_event(tcls_pkg::EVT_SYN, tcls_pkg::CODE_REPORT, 32'd0));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_X, 32'd0));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_Y, 32'd4095));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    send_event(make_event(tcls_pkg::EVT_SYN, tcls_pkg::CODE_REPORT, 32'd0));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_X, 32'd10));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_X, -32'sd5));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_Y, 32'd5000));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd2));
    send_event(make_event(EVT_REL, tcls_pkg::CODE_MT_X, 32'd77));
    send_event(make_event(tcls_pkg::EVT_ABS, CODE_MT_TRACK, 32'd9));
    send_event(make_event(tcls_pkg::EVT_SYN, tcls_pkg::CODE_MT_X, 32'd0));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_X, 32'h7FFF_FFFF));
    send_event(make_event(tcls_pkg::EVT_SYN, tcls_pkg::CODE_REPORT, 32'hFFFF_FFFF));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_Y, 32'h8000_0000));
    send_event(make_event(tcls_pkg::EVT_SYN, tcls_pkg::CODE_REPORT, 32'd0));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
  endtask

  // Full 32-bit ranges, widest screen, largest and zero move limits
  task automatic test_extreme_ranges();
    settle();
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h1FFF, 32'hFFFF_1000, 32'hFFFF_FFFF);
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_X, 32'h8000_0000));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_Y, 32'h7FFF_FFFF));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_X, 32'h7FFF_FFFF));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_Y, 32'h8000_0000));
    send_event(make_event(tcls_pkg::EVT_SYN, tcls_pkg::CODE_REPORT, 32'd0));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
    repeat (4) run_gesture();
    settle();
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'd4096, 32'd1, 32'd0);
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
    repeat (4) run_gesture();
  endtask

  // Zero and negative spans, screen sizes of zero and one
  task automatic test_degenerate_ranges();
    settle();
    program_regs(32'd100, 32'd100, 32'd500, -32'sd500, 32'd0, 32'd4096, 32'd5);
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_X, 32'd99));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_Y, 32'd500));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_Y, 32'd501));
    send_event(make_event(tcls_pkg::EVT_SYN, tcls_pkg::CODE_REPORT, 32'd0));
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_Y, 32'd499));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
    repeat (4) run_gesture();
    settle();
    program_regs(-32'sd7, -32'sd7, 32'd0, 32'd1, 32'd3000, 32'd1, 32'd1);
    send_event(make_event(tcls_pkg::EVT_ABS, tcls_pkg::CODE_MT_X, -32'sd6));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
    repeat (4) run_gesture();
  endtask

  // Hold the result side off for a long stretch while beats keep coming
  task automatic test_backpressure();
    settle();
    calm = 1'b1;
    hold_off_req <= 1'b1;
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd1));
    repeat (6) send_event(make_event(tcls_pkg::EVT_SYN, tcls_pkg::CODE_REPORT, $urandom));
    send_event(make_event(tcls_pkg::EVT_KEY, tcls_pkg::CODE_TOUCH, 32'd0));
    repeat (3) run_gesture();
    settle();
    hold_off_req <= 1'b0;
    calm = 1'b0;
  endtask

  // Random settings per phase, mostly well-formed gestures with some noise
  task automatic test_random_streams();
    logic [31:0] xl, xh, yl, yh, lim;
    while (items_sent < ITEM_TARGET) begin
      settle();
      random_range(xl, xh);
      random_range(yl, yh);
      case ($urandom_range(0, 5))
        0: lim = 32'd0;
        1: lim = 32'hFFFF_FFFF;
        default: lim = $urandom_range(1, 400);
      endcase
      program_regs(xl, xh, yl, yh, random_size(), random_size(), lim);
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(15, 30)) begin
        if (items_sent >= ITEM_TARGET) break;
        if ($urandom_range(0, 4) != 0) run_gesture();
        else send_event(noise_event());
      end
    end
    calm = 1'b0;
  endtask

  // Result side stall: one long hold on request, otherwise random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_taken) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_taken = 1'b1;
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        case ($urandom_range(0, 19))
          0: stall_left = $urandom_range(20, 60);
          1, 2: stall_left = $urandom_range(4, 10);
          default: stall_left = $urandom_range(0, 2);
        endcase
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result beat with the oldest expected touch
  always @(posedge clk) begin : check_results
    tcls_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_touches.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d x %0d y %0d tap %0d",
                                  out_data.touch_kind, out_data.screen_x,
                                  out_data.screen_y, out_data.is_tap));
      end else begin
        want = expected_touches.pop_front();
        if (out_data.touch_kind !== want.touch_kind || out_data.screen_x !== want.screen_x
            || out_data.screen_y !== want.screen_y || out_data.is_tap !== want.is_tap) begin
          report_mismatch($sformatf("got kind %0d x %0d y %0d tap %0d, want %0d %0d %0d %0d",
                                    out_data.touch_kind, out_data.screen_x, out_data.screen_y,
                                    out_data.is_tap, want.touch_kind, want.screen_x,
                                    want.screen_y, want.is_tap));
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_extreme_ranges();
    test_degenerate_ranges();
    test_backpressure();
    test_random_streams();
    settle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
